// ===== hw/rtl/sshit_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere hit test package
// Shared widths, pipeline depths and stage side-band types.
// ----------------------------------------------------------------------------
package sshit_pkg;

   localparam int COORD_W    = 16;
   localparam int A_W        = 32;
   localparam int H_W        = 34;
   localparam int C_W        = 35;
   localparam int DISC_W     = 68;
   localparam int ROOT_W     = 34;
   localparam int REM_W      = 37;
   localparam int SQRT_STEPS = 34;
   localparam int T_W        = 17;
   localparam int DIV_STEPS  = 17;
   localparam int NUM_W      = 33;
   localparam int N_W        = 36;
   localparam int FRONT_LAT  = 5;
   localparam int PIPE_LAT   = FRONT_LAT + SQRT_STEPS + 1 + DIV_STEPS;

   typedef struct packed {
      logic                  ok;
      logic signed [H_W-1:0] h;
      logic [A_W-1:0]        a;
   } sqrt_side_type;

endpackage

// ===== hw/rtl/sshit_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of the discriminant, one result bit per stage.
// ----------------------------------------------------------------------------
module sshit_sqrt
   import sshit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [DISC_W-1:0]   in_disc,
   input  sqrt_side_type       in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output sqrt_side_type       out_side
);

   logic                valid_ff [SQRT_STEPS];
   logic [DISC_W-1:0]   disc_ff  [SQRT_STEPS];
   logic [REM_W-1:0]    rem_ff   [SQRT_STEPS];
   logic [ROOT_W-1:0]   root_ff  [SQRT_STEPS];
   sqrt_side_type       side_ff  [SQRT_STEPS];

   logic                prev_valid [SQRT_STEPS];
   logic [DISC_W-1:0]   prev_disc  [SQRT_STEPS];
   logic [REM_W-1:0]    prev_rem   [SQRT_STEPS];
   logic [ROOT_W-1:0]   prev_root  [SQRT_STEPS];
   sqrt_side_type       prev_side  [SQRT_STEPS];

   genvar k;
   generate
      for (k = 0; k < SQRT_STEPS; k++) begin : g_step
         logic [REM_W-1:0]  rem_sh;
         logic [REM_W-1:0]  trial;
         logic              ge;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign prev_valid[k] = in_valid;
            assign prev_disc[k]  = in_disc;
            assign prev_rem[k]   = '0;
            assign prev_root[k]  = '0;
            assign prev_side[k]  = in_side;
         end else begin : g_next
            assign prev_valid[k] = valid_ff[k-1];
            assign prev_disc[k]  = disc_ff[k-1];
            assign prev_rem[k]   = rem_ff[k-1];
            assign prev_root[k]  = root_ff[k-1];
            assign prev_side[k]  = side_ff[k-1];
         end

         assign rem_sh  = {prev_rem[k][REM_W-3:0], prev_disc[k][DISC_W-1 -: 2]};
         assign trial   = {1'b0, prev_root[k], 2'b01};
         assign ge      = (rem_sh >= trial);
         assign rem_in  = ge ? (rem_sh - trial) : rem_sh;
         assign root_in = {prev_root[k][ROOT_W-2:0], ge};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= prev_valid[k];
            end
            disc_ff[k] <= {prev_disc[k][DISC_W-3:0], 2'b00};
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= prev_side[k];
         end
      end
   endgenerate

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/sshit_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of num * 2^16 by den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sshit_div
   import sshit_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_hit,
   input  logic [A_W-1:0]   in_num,
   input  logic [A_W-1:0]   in_den,
   output logic             out_valid,
   output logic             out_hit,
   output logic [T_W-1:0]   out_t
);

   logic             valid_ff [DIV_STEPS];
   logic             hit_ff   [DIV_STEPS];
   logic [A_W-1:0]   rem_ff   [DIV_STEPS];
   logic [A_W-1:0]   den_ff   [DIV_STEPS];
   logic [T_W-1:0]   quo_ff   [DIV_STEPS];

   logic             prev_valid [DIV_STEPS];
   logic             prev_hit   [DIV_STEPS];
   logic [A_W-1:0]   prev_rem   [DIV_STEPS];
   logic [A_W-1:0]   prev_den   [DIV_STEPS];
   logic [T_W-1:0]   prev_quo   [DIV_STEPS];

   genvar j;
   generate
      for (j = 0; j < DIV_STEPS; j++) begin : g_step
         logic [NUM_W-1:0] sh;
         logic             ge;
         logic [NUM_W-1:0] diff;

         if (j == 0) begin : g_first
            assign prev_valid[j] = in_valid;
            assign prev_hit[j]   = in_hit;
            assign prev_rem[j]   = in_num;
            assign prev_den[j]   = in_den;
            assign prev_quo[j]   = '0;
            assign sh            = {1'b0, prev_rem[j]};
         end else begin : g_next
            assign prev_valid[j] = valid_ff[j-1];
            assign prev_hit[j]   = hit_ff[j-1];
            assign prev_rem[j]   = rem_ff[j-1];
            assign prev_den[j]   = den_ff[j-1];
            assign prev_quo[j]   = quo_ff[j-1];
            assign sh            = {prev_rem[j], 1'b0};
         end

         assign ge   = (sh >= {1'b0, prev_den[j]});
         assign diff = sh - {1'b0, prev_den[j]};

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[j] <= 1'b0;
            end else begin
               valid_ff[j] <= prev_valid[j];
            end
            hit_ff[j] <= prev_hit[j];
            den_ff[j] <= prev_den[j];
            rem_ff[j] <= ge ? diff[A_W-1:0] : sh[A_W-1:0];
            quo_ff[j] <= {prev_quo[j][T_W-2:0], ge};
         end
      end
   endgenerate

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_hit   = hit_ff[DIV_STEPS-1];
   assign out_t     = hit_ff[DIV_STEPS-1] ? quo_ff[DIV_STEPS-1] : '0;

endmodule

// ===== hw/rtl/segment_sphere_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// Segment/sphere hit test
// Tests a segment against a sphere and returns the nearest crossing in [0,1].
//
// Usage:
//   Drive the req_ fields and pulse start; a transaction is taken on every
//   clock edge with start high and busy low. busy is never raised, so one
//   test can enter every cycle.
//   Each transaction yields exactly one result, shown for one cycle with
//   rsp_valid high, after the transaction has passed every stage below.
//   Pipeline: 5 front stages (differences, products, dot sums, wide
//   products, discriminant), 34 square root stages (one root bit each),
//   one root select stage and 17 divider stages (one t bit each).
//   Throughput: one transaction per cycle.
//   rsp_nearest_t is Q1.16 (65536 is 1.0) and is zero without a hit.
//   Reset clears all stage valid bits; transactions in flight are dropped.
//   The receiver cannot stall; results are taken as they appear.
// ----------------------------------------------------------------------------
module segment_sphere_hit_test_top
   import sshit_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0] req_seg_start_x,
   input  logic signed [COORD_W-1:0] req_seg_start_y,
   input  logic signed [COORD_W-1:0] req_seg_start_z,
   input  logic signed [COORD_W-1:0] req_seg_dir_x,
   input  logic signed [COORD_W-1:0] req_seg_dir_y,
   input  logic signed [COORD_W-1:0] req_seg_dir_z,
   input  logic signed [COORD_W-1:0] req_sphere_x,
   input  logic signed [COORD_W-1:0] req_sphere_y,
   input  logic signed [COORD_W-1:0] req_sphere_z,
   input  logic [COORD_W-1:0]        req_sphere_radius,
   input  logic                       req_skip,
   input  logic                       req_other_is_sphere,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [T_W-1:0]            rsp_nearest_t
);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // stage 1: differences
   logic                     v1_ff, en1_ff;
   logic signed [16:0]       ex1_ff, ey1_ff, ez1_ff;
   logic signed [15:0]       dx1_ff, dy1_ff, dz1_ff;
   logic [15:0]              rad1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      en1_ff  <= ~req_skip & req_other_is_sphere;
      ex1_ff  <= {req_seg_start_x[15], req_seg_start_x} - {req_sphere_x[15], req_sphere_x};
      ey1_ff  <= {req_seg_start_y[15], req_seg_start_y} - {req_sphere_y[15], req_sphere_y};
      ez1_ff  <= {req_seg_start_z[15], req_seg_start_z} - {req_sphere_z[15], req_sphere_z};
      dx1_ff  <= req_seg_dir_x;
      dy1_ff  <= req_seg_dir_y;
      dz1_ff  <= req_seg_dir_z;
      rad1_ff <= req_sphere_radius;
   end

   // stage 2: products
   logic                     v2_ff, en2_ff;
   logic signed [31:0]       dxx2_ff, dyy2_ff, dzz2_ff;
   logic signed [32:0]       dex2_ff, dey2_ff, dez2_ff;
   logic signed [33:0]       exx2_ff, eyy2_ff, ezz2_ff;
   logic [31:0]              rr2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      en2_ff  <= en1_ff;
      dxx2_ff <= dx1_ff * dx1_ff;
      dyy2_ff <= dy1_ff * dy1_ff;
      dzz2_ff <= dz1_ff * dz1_ff;
      dex2_ff <= dx1_ff * ex1_ff;
      dey2_ff <= dy1_ff * ey1_ff;
      dez2_ff <= dz1_ff * ez1_ff;
      exx2_ff <= ex1_ff * ex1_ff;
      eyy2_ff <= ey1_ff * ey1_ff;
      ezz2_ff <= ez1_ff * ez1_ff;
      rr2_ff  <= rad1_ff * rad1_ff;
   end

   // stage 3: dot sums
   logic                     v3_ff, en3_ff;
   logic [A_W-1:0]           a3_ff;
   logic signed [H_W-1:0]    h3_ff;
   logic signed [C_W-1:0]    c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      en3_ff <= en2_ff;
      a3_ff  <= A_W'(dxx2_ff) + A_W'(dyy2_ff) + A_W'(dzz2_ff);
      h3_ff  <= H_W'(dex2_ff) + H_W'(dey2_ff) + H_W'(dez2_ff);
      c3_ff  <= C_W'(exx2_ff) + C_W'(eyy2_ff) + C_W'(ezz2_ff) - C_W'(rr2_ff);
   end

   // stage 4: h^2 and a*|c|
   logic [32:0]              habs;
   logic [33:0]              cabs;
   logic                     v4_ff, ok4_ff, cneg4_ff;
   logic [65:0]              h24_ff, ac4_ff;
   logic [A_W-1:0]           a4_ff;
   logic signed [H_W-1:0]    h4_ff;

   assign habs = h3_ff[H_W-1] ? 33'(-h3_ff) : 33'(h3_ff);
   assign cabs = c3_ff[C_W-1] ? 34'(-c3_ff) : 34'(c3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      ok4_ff   <= en3_ff & (a3_ff != '0);
      cneg4_ff <= c3_ff[C_W-1];
      h24_ff   <= habs * habs;
      ac4_ff   <= a3_ff * cabs;
      a4_ff    <= a3_ff;
      h4_ff    <= h3_ff;
   end

   // stage 5: discriminant
   logic                     v5_ff;
   logic [DISC_W-1:0]        disc5_ff;
   sqrt_side_type            side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      disc5_ff    <= cneg4_ff ? (DISC_W'(h24_ff) + DISC_W'(ac4_ff))
                              : (DISC_W'(h24_ff) - DISC_W'(ac4_ff));
      side5_ff.ok <= ok4_ff & (cneg4_ff | (ac4_ff <= h24_ff));
      side5_ff.h  <= h4_ff;
      side5_ff.a  <= a4_ff;
   end

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   sqrt_side_type     sq_side;

   sshit_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_disc   (disc5_ff),
      .in_side   (side5_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // root select
   logic signed [N_W-1:0] hx, sx, an, n2, n1;
   logic                  n2_ok, n1_ok;
   logic                  vs_ff, hits_ff;
   logic [A_W-1:0]        nums_ff, dens_ff;

   assign hx    = N_W'(sq_side.h);
   assign sx    = signed'(N_W'(sq_root));
   assign an    = signed'(N_W'(sq_side.a));
   assign n2    = -hx - sx;
   assign n1    = -hx + sx;
   assign n2_ok = ~n2[N_W-1] & (n2 <= an);
   assign n1_ok = ~n1[N_W-1] & (n1 <= an);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else begin
         vs_ff <= sq_valid;
      end
      hits_ff <= sq_side.ok & (n2_ok | n1_ok);
      nums_ff <= n2_ok ? n2[A_W-1:0] : n1[A_W-1:0];
      dens_ff <= sq_side.a;
   end

   sshit_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vs_ff),
      .in_hit    (hits_ff),
      .in_num    (nums_ff),
      .in_den    (dens_ff),
      .out_valid (rsp_valid),
      .out_hit   (rsp_hit),
      .out_t     (rsp_nearest_t)
   );

`ifndef SYNTHESIS
   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, PIPE_LAT))
      else $error("result without matching transaction");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_nearest_t == '0))
      else $error("nonzero t without hit");
   a_t_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nearest_t[T_W-1]) |-> (rsp_nearest_t[T_W-2:0] == '0))
      else $error("t above 1.0");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment/sphere hit test bench
// Streams directed and random segment/sphere pairs into the block, predicts
// the hit flag and nearest crossing t for each, and compares every result.
// ----------------------------------------------------------------------------
module tb_top
   import sshit_pkg::*;
();

   typedef struct {
      logic signed [COORD_W-1:0] px, py, pz, dx, dy, dz, cx, cy, cz;
      logic [COORD_W-1:0]        rad;
      logic                      skip, is_sphere;
   } pair_type;

   typedef struct {
      logic           hit;
      logic [T_W-1:0] t;
   } crossing_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [COORD_W-1:0] req_seg_start_x = 0, req_seg_start_y = 0, req_seg_start_z = 0;
   logic signed [COORD_W-1:0] req_seg_dir_x = 0, req_seg_dir_y = 0, req_seg_dir_z = 0;
   logic signed [COORD_W-1:0] req_sphere_x = 0, req_sphere_y = 0, req_sphere_z = 0;
   logic [COORD_W-1:0]        req_sphere_radius = 0;
   logic                      req_skip = 0, req_other_is_sphere = 0;
   logic                      rsp_valid, rsp_hit;
   logic [T_W-1:0]            rsp_nearest_t;

   pair_type     pending_pairs[$];
   crossing_type expected_crossings[$];
   int           idle_pct = 13;
   bit           hold = 0;
   int           errors = 0;
   int           n_sent = 0, n_hits = 0, n_results = 0;
   int           quiet = 0;

   always #6 clock = ~clock;

   segment_sphere_hit_test_top dut (.*);

   function automatic crossing_type predict_crossing(pair_type p);
      crossing_type r;
      longint dx, dy, dz, ex, ey, ez, a, h, c, n;
      logic signed [127:0] disc, cand, s;
      r.hit = 0;
      r.t = 0;
      if (p.skip || !p.is_sphere) return r;
      dx = p.dx; dy = p.dy; dz = p.dz;
      ex = longint'(p.px) - p.cx;
      ey = longint'(p.py) - p.cy;
      ez = longint'(p.pz) - p.cz;
      a = dx*dx + dy*dy + dz*dz;
      if (a == 0) return r;
      h = dx*ex + dy*ey + dz*ez;
      c = ex*ex + ey*ey + ez*ez - longint'(p.rad) * longint'(p.rad);
      disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
      if (disc < 0) return r;
      s = 0;
      for (int b = 34; b >= 0; b--) begin
         cand = s | (128'(1) << b);
         if (cand * cand <= disc) s = cand;
      end
      n = -h - longint'(s);
      if (n < 0 || n > a) begin
         n = -h + longint'(s);
         if (n < 0 || n > a) return r;
      end
      r.hit = 1;
      r.t = T_W'((n << 16) / a);
      return r;
   endfunction

   function automatic pair_type mk(int px, int py, int pz, int dx, int dy, int dz,
                                   int cx, int cy, int cz, int rad, bit sk, bit sp);
      pair_type p;
      p.px = COORD_W'(px); p.py = COORD_W'(py); p.pz = COORD_W'(pz);
      p.dx = COORD_W'(dx); p.dy = COORD_W'(dy); p.dz = COORD_W'(dz);
      p.cx = COORD_W'(cx); p.cy = COORD_W'(cy); p.cz = COORD_W'(cz);
      p.rad = COORD_W'(rad); p.skip = sk; p.is_sphere = sp;
      return p;
   endfunction

   function automatic int rnd_s(int span);
      return int'($urandom_range(2*span)) - span;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int       k;
      k = $urandom_range(99);
      if (k < 20) begin
         p.px = COORD_W'($urandom); p.py = COORD_W'($urandom); p.pz = COORD_W'($urandom);
         p.dx = COORD_W'($urandom); p.dy = COORD_W'($urandom); p.dz = COORD_W'($urandom);
         p.cx = COORD_W'($urandom); p.cy = COORD_W'($urandom); p.cz = COORD_W'($urandom);
         p.rad = COORD_W'($urandom);
      end else begin
         p.cx = COORD_W'(rnd_s(8192));
         p.cy = COORD_W'(rnd_s(8192));
         p.cz = COORD_W'(rnd_s(8192));
         p.rad = COORD_W'($urandom_range(k < 30 ? 65535 : 1536));
         p.px = COORD_W'(p.cx + rnd_s(3072));
         p.py = COORD_W'(p.cy + rnd_s(3072));
         p.pz = COORD_W'(p.cz + rnd_s(3072));
         p.dx = COORD_W'(rnd_s(k < 40 ? 32767 : 4096));
         p.dy = COORD_W'(rnd_s(4096));
         p.dz = COORD_W'(rnd_s(4096));
         if (k < 45) begin
            p.dx = p.cx - p.px; p.dy = p.cy - p.py; p.dz = p.cz - p.pz;
         end
      end
      p.skip = ($urandom_range(99) < 10);
      p.is_sphere = ($urandom_range(99) >= 10);
      return p;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset && !hold && pending_pairs.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
         start               <= 1;
         req_seg_start_x     <= pending_pairs[0].px;
         req_seg_start_y     <= pending_pairs[0].py;
         req_seg_start_z     <= pending_pairs[0].pz;
         req_seg_dir_x       <= pending_pairs[0].dx;
         req_seg_dir_y       <= pending_pairs[0].dy;
         req_seg_dir_z       <= pending_pairs[0].dz;
         req_sphere_x        <= pending_pairs[0].cx;
         req_sphere_y        <= pending_pairs[0].cy;
         req_sphere_z        <= pending_pairs[0].cz;
         req_sphere_radius   <= pending_pairs[0].rad;
         req_skip            <= pending_pairs[0].skip;
         req_other_is_sphere <= pending_pairs[0].is_sphere;
      end else begin
         start <= 0;
      end
   end

   // accept transactions and check results
   always @(posedge clock) begin
      crossing_type e;
      if (!reset) begin
         quiet = quiet + 1;
         if (start && !busy) begin
            expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
            n_sent = n_sent + 1;
            quiet = 0;
         end
         if (rsp_valid) begin
            quiet = 0;
            n_results = n_results + 1;
            if (expected_crossings.size() == 0) begin
               $error("result with no transaction outstanding");
               errors = errors + 1;
            end else begin
               e = expected_crossings.pop_front();
               if (e.hit) n_hits = n_hits + 1;
               if (rsp_hit !== e.hit) begin
                  $error("hit: expected %0d actual %0d", e.hit, rsp_hit);
                  errors = errors + 1;
               end
               if (rsp_nearest_t !== e.t) begin
                  $error("nearest_t: expected %0d actual %0d", e.t, rsp_nearest_t);
                  errors = errors + 1;
               end
            end
         end
         if (quiet >= 3000) begin
            $display("timeout waiting for transactions");
            $display("segment_sphere_hit_test_top: mismatch");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock) reset = 0;
      // extremes, exclusions, zero length, tangent, start inside, miss
      pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                 32767, 32767, 32767, 65535, 0, 1));
      pending_pairs.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
                                 -32768, -32768, -32768, 0, 0, 1));
      pending_pairs.push_back(mk(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 65535, 0, 1));
      pending_pairs.push_back(mk(0, 0, 0, 256, 0, 0, 0, 0, 0, 512, 1, 1));
      pending_pairs.push_back(mk(0, 0, 0, 256, 0, 0, 0, 0, 0, 512, 0, 0));
      pending_pairs.push_back(mk(0, 0, 0, 256, 0, 0, 0, 0, 0, 512, 1, 0));
      pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 512, 0, 1));
      pending_pairs.push_back(mk(-512, 256, 0, 1024, 0, 0, 0, 0, 0, 256, 0, 1));
      pending_pairs.push_back(mk(0, 0, 0, 1024, 0, 0, 0, 0, 0, 512, 0, 1));
      pending_pairs.push_back(mk(0, 0, 0, 1024, 512, 256, 0, 0, 0, 0, 0, 1));
      pending_pairs.push_back(mk(-1024, 0, 0, 2048, 0, 0, 0, 0, 0, 256, 0, 1));
      pending_pairs.push_back(mk(-1024, 0, 0, 768, 0, 0, 0, 0, 0, 256, 0, 1));
      pending_pairs.push_back(mk(-1024, 0, 0, 512, 0, 0, 0, 0, 0, 256, 0, 1));
      pending_pairs.push_back(mk(0, 1024, 0, 1024, 0, 0, 0, 0, 0, 256, 0, 1));
      pending_pairs.push_back(mk(-256, 0, 0, 256, 0, 0, 0, 0, 0, 0, 0, 1));
      pending_pairs.push_back(mk(0, -1, 1, -1, 1, -1, 0, 0, 0, 1, 0, 1));
      for (int i = 0; i < 230; i++) pending_pairs.push_back(random_pair());
      wait (pending_pairs.size() == 0);
      hold = 1;
      wait (expected_crossings.size() == 0);
      hold = 0;
      idle_pct = 86;
      for (int i = 0; i < 230; i++) pending_pairs.push_back(random_pair());
      wait (pending_pairs.size() == 0);
      idle_pct = 0;
      for (int i = 0; i < 240; i++) pending_pairs.push_back(random_pair());
      wait (pending_pairs.size() == 0);
      wait (expected_crossings.size() == 0);
      repeat (PIPE_LAT + 10) @(posedge clock);
      $display("%0d tests sent, %0d results checked, %0d hits", n_sent, n_results, n_hits);
      $display("sender idle 13%% / 86%% / none, one drain pause mid-run");
      if (errors == 0)
         $display("segment_sphere_hit_test_top: match");
      else
         $display("segment_sphere_hit_test_top: mismatch");
      $finish;
   end

endmodule
